// File: hw/rtl/stsd_pkg.sv
// Shared types and constants for the sphere triangle subdivider.
// No dependencies.
package stsd_pkg;

  localparam int COORD_W    = 16;  // Q2.14 coordinate as carried on the ports
  localparam int SUM_W      = 17;  // edge sum p+q per axis
  localparam int SQ_W       = 34;  // sum of three squares
  localparam int GUARD_BITS = 8;   // extra fraction bits on the length
  localparam int RAD_W      = 50;  // radicand: squared length << 2*GUARD_BITS
  localparam int ROOT_W     = 25;  // integer square root of the radicand

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // projected edge midpoint plus zero-length flag
  typedef struct packed {
    vec_t p;
    logic zero;
  } mid_t;

  // which of the four sub-triangles goes out
  typedef enum logic [1:0] {
    SUB_V0  = 2'd0,
    SUB_V1  = 2'd1,
    SUB_V2  = 2'd2,
    SUB_MID = 2'd3
  } sub_t;

endpackage

// File: hw/rtl/stsd_if.sv
// Valid/ready channel interfaces for the triangle subdivider.
// Depends on stsd_pkg.
interface stsd_in_if;
  import stsd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t corner_a_x;
  coord_t corner_a_y;
  coord_t corner_a_z;
  coord_t corner_b_x;
  coord_t corner_b_y;
  coord_t corner_b_z;
  coord_t corner_c_x;
  coord_t corner_c_y;
  coord_t corner_c_z;

  modport source (output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x,
                  corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
                  input ready);
  modport sink (input valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x,
                corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
                output ready);
endinterface

interface stsd_out_if;
  import stsd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t tri_p_x;
  coord_t tri_p_y;
  coord_t tri_p_z;
  coord_t tri_q_x;
  coord_t tri_q_y;
  coord_t tri_q_z;
  coord_t tri_r_x;
  coord_t tri_r_y;
  coord_t tri_r_z;
  logic   last_triangle;
  logic   degenerate;

  modport source (output valid, tri_p_x, tri_p_y, tri_p_z, tri_q_x, tri_q_y,
                  tri_q_z, tri_r_x, tri_r_y, tri_r_z, last_triangle, degenerate,
                  input ready);
  modport sink (input valid, tri_p_x, tri_p_y, tri_p_z, tri_q_x, tri_q_y,
                tri_q_z, tri_r_x, tri_r_y, tri_r_z, last_triangle, degenerate,
                output ready);
endinterface

// File: hw/rtl/stsd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on stsd_pkg.
module stsd_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [stsd_pkg::RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        out_valid,
  output logic [stsd_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]           side_o
);
  import stsd_pkg::*;

  localparam int NST = ROOT_W;

  // the last stage keeps no remainder
  logic [RAD_W-1:0]  v_r   [NST-1];
  logic [RAD_W-1:0]  res_r [NST];
  logic [SIDE_W-1:0] side_r[NST];
  logic [NST-1:0]    vld_r;

  logic [RAD_W-1:0]  v_in   [NST];
  logic [RAD_W-1:0]  res_in [NST];
  logic [SIDE_W-1:0] side_in[NST];

  always_comb begin
    v_in[0]    = rad;
    res_in[0]  = '0;
    side_in[0] = side_i;
    for (int k = 1; k < NST; k++) begin
      v_in[k]    = v_r[k-1];
      res_in[k]  = res_r[k-1];
      side_in[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] trial;
    logic             fits;
    assign trial = res_in[k] + BIT;
    assign fits  = (v_in[k] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k]  <= fits ? ((res_in[k] >> 1) + BIT) : (res_in[k] >> 1);
        side_r[k] <= side_in[k];
      end
    end

    if (k < NST - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[k] <= fits ? (v_in[k] - trial) : v_in[k];
        end
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign root      = res_r[NST-1][ROOT_W-1:0];
  assign side_o    = side_r[NST-1];

endmodule

// File: hw/rtl/stsd_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Depends on stsd_pkg for the divisor width.
module stsd_div #(
  parameter int NUM_W  = 40,
  parameter int QUO_W  = 15,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [NUM_W-1:0]            num,
  input  logic [stsd_pkg::ROOT_W-1:0] den,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        out_valid,
  output logic [QUO_W-1:0]            quo,
  output logic [SIDE_W-1:0]           side_o
);
  import stsd_pkg::*;

  // the last stage keeps no remainder or divisor
  logic [NUM_W-1:0]  rem_r [QUO_W-1];
  logic [ROOT_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0]  q_r   [QUO_W];
  logic [SIDE_W-1:0] side_r[QUO_W];
  logic [QUO_W-1:0]  vld_r;

  logic [NUM_W-1:0]  rem_in [QUO_W];
  logic [ROOT_W-1:0] den_in [QUO_W];
  logic [QUO_W-1:0]  q_in   [QUO_W];
  logic [SIDE_W-1:0] side_in[QUO_W];

  always_comb begin
    rem_in[0]  = num;
    den_in[0]  = den;
    q_in[0]    = '0;
    side_in[0] = side_i;
    for (int k = 1; k < QUO_W; k++) begin
      rem_in[k]  = rem_r[k-1];
      den_in[k]  = den_r[k-1];
      q_in[k]    = q_r[k-1];
      side_in[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [NUM_W-1:0] dsh;
    logic             fits;
    assign dsh  = NUM_W'(den_in[k]) << SH;
    assign fits = (rem_in[k] >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]     <= q_in[k] | (fits ? (QUO_W'(1) << SH) : '0);
        side_r[k]  <= side_in[k];
      end
    end

    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fits ? (rem_in[k] - dsh) : rem_in[k];
          den_r[k] <= den_in[k];
        end
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign quo       = q_r[QUO_W-1];
  assign side_o    = side_r[QUO_W-1];

endmodule

// File: hw/rtl/stsd_edge_proj.sv
// Edge midpoint projection: sum, squares, length, per-axis divide, round.
// Depends on stsd_pkg, stsd_sqrt and stsd_div.
module stsd_edge_proj #(
  parameter int FRAC = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  stsd_pkg::vec_t  pa,
  input  stsd_pkg::vec_t  pb,
  output logic            out_valid,
  output stsd_pkg::mid_t  mid
);
  import stsd_pkg::*;

  localparam int NUM_W = SUM_W + FRAC + GUARD_BITS + 1;
  localparam int QUO_W = FRAC + 1;

  logic [2:0] vld_r;

  // stage 1: edge sums
  logic signed [SUM_W-1:0] s1_r[3];
  // stage 2: squares
  logic signed [SUM_W-1:0] s2_r[3];
  logic [SQ_W-1:0]         sq2_r[3];
  // stage 3: squared length
  logic signed [SUM_W-1:0] s3_r[3];
  logic [SQ_W-1:0]         len2_r;

  coord_t pa_c[3];
  coord_t pb_c[3];
  logic signed [SQ_W-1:0] prod[3];

  assign pa_c = '{pa.x, pa.y, pa.z};
  assign pb_c = '{pb.x, pb.y, pb.z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = SQ_W'(s1_r[i]) * SQ_W'(s1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_r[i]  <= SUM_W'(pa_c[i]) + SUM_W'(pb_c[i]);
        s2_r[i]  <= s1_r[i];
        sq2_r[i] <= prod[i];
        s3_r[i]  <= s2_r[i];
      end
      len2_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    end
  end

  // length with guard bits
  logic                   sq_vld;
  logic [ROOT_W-1:0]      root;
  logic [3*SUM_W-1:0]     sq_side;

  stsd_sqrt #(.SIDE_W(3 * SUM_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r[2]),
    .rad       ({len2_r, 16'b0}),
    .side_i    ({s3_r[0], s3_r[1], s3_r[2]}),
    .out_valid (sq_vld),
    .root      (root),
    .side_o    (sq_side)
  );

  // prep stage: magnitudes and rounded numerators
  logic signed [SUM_W-1:0] sq_s[3];
  logic [SUM_W-1:0]        mag[3];
  logic                    pr_vld_r;
  logic [NUM_W-1:0]        num_r[3];
  logic [ROOT_W-1:0]       den_r;
  logic                    neg_r[3];
  logic                    zero_r;

  assign sq_s[0] = sq_side[3*SUM_W-1:2*SUM_W];
  assign sq_s[1] = sq_side[2*SUM_W-1:SUM_W];
  assign sq_s[2] = sq_side[SUM_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = sq_s[i][SUM_W-1] ? SUM_W'(-sq_s[i]) : SUM_W'(sq_s[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else if (en) begin
      pr_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(mag[i]) << (FRAC + GUARD_BITS)) + NUM_W'(root >> 1);
        neg_r[i] <= sq_s[i][SUM_W-1];
      end
      den_r  <= root;
      zero_r <= (root == '0);
    end
  end

  // per-axis dividers
  logic             dv_vld;
  logic [QUO_W-1:0] quo_x, quo_y, quo_z;
  logic [1:0]       side_x;
  logic             neg_y, neg_z;

  stsd_div #(.NUM_W(NUM_W), .QUO_W(QUO_W), .SIDE_W(2)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pr_vld_r),
    .num(num_r[0]), .den(den_r), .side_i({zero_r, neg_r[0]}),
    .out_valid(dv_vld), .quo(quo_x), .side_o(side_x)
  );

  stsd_div #(.NUM_W(NUM_W), .QUO_W(QUO_W), .SIDE_W(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pr_vld_r),
    .num(num_r[1]), .den(den_r), .side_i(neg_r[1]),
    .out_valid(), .quo(quo_y), .side_o(neg_y)
  );

  stsd_div #(.NUM_W(NUM_W), .QUO_W(QUO_W), .SIDE_W(1)) u_div_z (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pr_vld_r),
    .num(num_r[2]), .den(den_r), .side_i(neg_r[2]),
    .out_valid(), .quo(quo_z), .side_o(neg_z)
  );

  // final stage: clamp to one, apply sign, zero for a degenerate edge
  localparam logic [63:0] ONE = 64'(1) << FRAC;

  function automatic coord_t to_coord(input logic [QUO_W-1:0] q, input logic neg,
                                      input logic zero);
    logic [63:0] mag64;
    logic [63:0] val;
    mag64 = 64'(q);
    if (mag64 > ONE) mag64 = ONE;
    val = neg ? (64'(0) - mag64) : mag64;
    return zero ? '0 : val[COORD_W-1:0];
  endfunction

  logic fin_vld_r;
  mid_t mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r.p.x  <= to_coord(quo_x, side_x[0], side_x[1]);
      mid_r.p.y  <= to_coord(quo_y, neg_y, side_x[1]);
      mid_r.p.z  <= to_coord(quo_z, neg_z, side_x[1]);
      mid_r.zero <= side_x[1];
    end
  end

  assign out_valid = fin_vld_r;
  assign mid       = mid_r;

endmodule

// File: hw/rtl/sphere_triangle_subdivide.sv
// Icosphere subdivision step: one triangle in, four sub-triangles out.
// Path to first result: edge projector pipeline, then the output holding register.
// Throughput: one result per cycle unless out_ch stalls; each input yields four results.
// Internal pipeline is fully registered; an item may enter in any cycle it advances.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
// Depends on stsd_pkg, stsd_if, stsd_edge_proj.
module sphere_triangle_subdivide #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  stsd_in_if.sink     in_ch,
  stsd_out_if.source  out_ch
);
  import stsd_pkg::*;

  // edge pipeline depth: sum, square, add, root, prep, divide, round
  localparam int LAT = 3 + ROOT_W + 1 + (COORD_FRAC_BITS + 1) + 1;

  logic pipe_en;     // global advance of the compute pipeline
  logic pipe_vld;    // bundle ready at pipeline tail
  logic load;        // tail bundle moves into the output holding register
  logic out_take;    // result transaction on out_ch

  vec_t v0_in, v1_in, v2_in;

  assign v0_in = '{in_ch.corner_a_x, in_ch.corner_a_y, in_ch.corner_a_z};
  assign v1_in = '{in_ch.corner_b_x, in_ch.corner_b_y, in_ch.corner_b_z};
  assign v2_in = '{in_ch.corner_c_x, in_ch.corner_c_y, in_ch.corner_c_z};

  // The pipeline stalls as a whole only when its tail holds a bundle that
  // the output stage cannot take.
  assign pipe_en     = !pipe_vld || load;
  assign in_ch.ready = pipe_en;

  // Edge projectors: a = v0v1, b = v1v2, c = v2v0
  mid_t mid_a, mid_b, mid_c;

  stsd_edge_proj #(.FRAC(COORD_FRAC_BITS)) u_edge_a (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(in_ch.valid),
    .pa(v0_in), .pb(v1_in), .out_valid(pipe_vld), .mid(mid_a)
  );

  stsd_edge_proj #(.FRAC(COORD_FRAC_BITS)) u_edge_b (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(in_ch.valid),
    .pa(v1_in), .pb(v2_in), .out_valid(), .mid(mid_b)
  );

  stsd_edge_proj #(.FRAC(COORD_FRAC_BITS)) u_edge_c (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(in_ch.valid),
    .pa(v2_in), .pb(v0_in), .out_valid(), .mid(mid_c)
  );

  // Original corners ride a delay line matched to the projector latency.
  vec_t v0_d_r[LAT];
  vec_t v1_d_r[LAT];
  vec_t v2_d_r[LAT];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      v0_d_r[0] <= v0_in;
      v1_d_r[0] <= v1_in;
      v2_d_r[0] <= v2_in;
      for (int k = 1; k < LAT; k++) begin
        v0_d_r[k] <= v0_d_r[k-1];
        v1_d_r[k] <= v1_d_r[k-1];
        v2_d_r[k] <= v2_d_r[k-1];
      end
    end
  end

  // Output holding register: one bundle, emitted as four transactions.
  logic full_r;
  sub_t cnt_r;
  vec_t v0_r, v1_r, v2_r, a_r, b_r, c_r;
  logic degen_r;
  logic last_sub;

  assign last_sub = (cnt_r == SUB_MID);
  assign out_take = full_r && out_ch.ready;
  assign load     = pipe_vld && (!full_r || (out_take && last_sub));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= SUB_V0;
    end else if (load) begin
      full_r <= 1'b1;
      cnt_r  <= SUB_V0;
    end else if (out_take) begin
      full_r <= !last_sub;
      cnt_r  <= sub_t'(2'(cnt_r + 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v0_r    <= v0_d_r[LAT-1];
      v1_r    <= v1_d_r[LAT-1];
      v2_r    <= v2_d_r[LAT-1];
      a_r     <= mid_a.p;
      b_r     <= mid_b.p;
      c_r     <= mid_c.p;
      degen_r <= mid_a.zero || mid_b.zero || mid_c.zero;
    end
  end

  // Sub-triangle select: (v0,a,c), (v1,b,a), (v2,b,c), (a,b,c)
  vec_t tp, tq, tr;

  always_comb begin
    case (cnt_r)
      SUB_V0: begin
        tp = v0_r; tq = a_r; tr = c_r;
      end
      SUB_V1: begin
        tp = v1_r; tq = b_r; tr = a_r;
      end
      SUB_V2: begin
        tp = v2_r; tq = b_r; tr = c_r;
      end
      default: begin
        tp = a_r; tq = b_r; tr = c_r;
      end
    endcase
  end

  assign out_ch.valid         = full_r;
  assign out_ch.tri_p_x       = tp.x;
  assign out_ch.tri_p_y       = tp.y;
  assign out_ch.tri_p_z       = tp.z;
  assign out_ch.tri_q_x       = tq.x;
  assign out_ch.tri_q_y       = tq.y;
  assign out_ch.tri_q_z       = tq.z;
  assign out_ch.tri_r_x       = tr.x;
  assign out_ch.tri_r_y       = tr.y;
  assign out_ch.tri_r_z       = tr.z;
  assign out_ch.last_triangle = last_sub;
  assign out_ch.degenerate    = degen_r;

endmodule

// File: hw/rtl/stsd_checker.sv
// Port-level checks for the triangle subdivider, bound to the top level.
// Depends on sphere_triangle_subdivide's channel ports only.
module stsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        last,
  input logic        degen,
  input logic [15:0] p_x
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(p_x) && $stable(last))
    else $error("stalled result changed");

  // the four results of one triangle come without a gap and share degenerate
  a_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> out_valid && $stable(degen))
    else $error("sub-triangle group broken");

  // a result after a last one must start a new group
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !(out_valid && last))
    else $error("last flag repeated");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sphere_triangle_subdivide stsd_checker u_stsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .last      (out_ch.last_triangle),
  .degen     (out_ch.degenerate),
  .p_x       (out_ch.tri_p_x)
);

// File: verif/sphere_triangle_subdivide_tb.sv
// Self-checking bench for sphere_triangle_subdivide: directed table, then random triangles.
// Fixed-point midpoint predictor checks every sub-triangle transaction.
// Depends on stsd_pkg, stsd_if and the RTL top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stsd_pkg::*;

  localparam int FRAC = 14;
  localparam int ONE = 1 << FRAC;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_in_t;

  typedef struct packed {
    vec_t p, q, r;
    logic last, degen;
  } sub_tri_t;

  // directed row: input plus optional typed-in first sub-triangle
  typedef struct {
    tri_in_t t;
    bit has_exp;
    sub_tri_t exp0;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  stsd_in_if in_ch();
  stsd_out_if out_ch();

  sphere_triangle_subdivide #(.COORD_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  sub_tri_t expected_tris[$];
  int errors = 0;
  int idle_cycles = 0;
  int n_in = 0, n_out = 0, n_degen = 0;
  bit sink_stall_on = 1;
  bit src_stall_on = 1;

  function automatic void queue_tri(sub_tri_t e);
    expected_tris.insert(expected_tris.size(), e);
  endfunction

  // integer square root, bitwise
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // project midpoint of edge p,q onto the sphere; zero flags a null edge sum
  function automatic vec_t sphere_mid(vec_t p, vec_t q, output bit zero);
    longint s[3];
    longint unsigned sq, len, mag, num;
    longint r;
    vec_t o;
    s[0] = longint'(p.x) + longint'(q.x);
    s[1] = longint'(p.y) + longint'(q.y);
    s[2] = longint'(p.z) + longint'(q.z);
    sq = s[0]*s[0] + s[1]*s[1] + s[2]*s[2];
    zero = (sq == 0);
    if (zero) return '0;
    len = int_sqrt(sq << (2*GUARD_BITS));
    for (int i = 0; i < 3; i++) begin
      mag = s[i] < 0 ? -s[i] : s[i];
      num = (mag << FRAC) << GUARD_BITS;
      r = (num + len/2) / len;
      if (r > ONE) r = ONE;
      if (s[i] < 0) r = -r;
      if (i == 0) o.x = r[15:0];
      else if (i == 1) o.y = r[15:0];
      else o.z = r[15:0];
    end
    return o;
  endfunction

  task automatic predict_subdivision(tri_in_t t);
    vec_t v0, v1, v2, a, b, c;
    bit za, zb, zc, dg;
    v0 = '{t.ax, t.ay, t.az};
    v1 = '{t.bx, t.by, t.bz};
    v2 = '{t.cx, t.cy, t.cz};
    a = sphere_mid(v0, v1, za);
    b = sphere_mid(v1, v2, zb);
    c = sphere_mid(v2, v0, zc);
    dg = za | zb | zc;
    if (dg) n_degen++;
    queue_tri('{v0, a, c, 1'b0, dg});
    queue_tri('{v1, b, a, 1'b0, dg});
    queue_tri('{v2, b, c, 1'b0, dg});
    queue_tri('{a, b, c, 1'b1, dg});
  endtask

  // per-axis compare of one sub-triangle vertex
  task automatic check_vec(string name, vec_t want, vec_t got);
    if (got.x !== want.x) begin
      $error("%s_x: expected %0d actual %0d", name, want.x, got.x); errors++;
    end
    if (got.y !== want.y) begin
      $error("%s_y: expected %0d actual %0d", name, want.y, got.y); errors++;
    end
    if (got.z !== want.z) begin
      $error("%s_z: expected %0d actual %0d", name, want.z, got.z); errors++;
    end
  endtask

  initial begin
    in_ch.valid = 0;
    {in_ch.corner_a_x, in_ch.corner_a_y, in_ch.corner_a_z, in_ch.corner_b_x,
     in_ch.corner_b_y, in_ch.corner_b_z, in_ch.corner_c_x, in_ch.corner_c_y,
     in_ch.corner_c_z} = '0;
    out_ch.ready = 0;
  end

  // result side: random stalls, compare each accepted transaction
  always @(posedge clk) begin
    sub_tri_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{'{out_ch.tri_p_x, out_ch.tri_p_y, out_ch.tri_p_z},
              '{out_ch.tri_q_x, out_ch.tri_q_y, out_ch.tri_q_z},
              '{out_ch.tri_r_x, out_ch.tri_r_y, out_ch.tri_r_z},
              out_ch.last_triangle, out_ch.degenerate};
      n_out++;
      if (expected_tris.size() == 0) begin
        $error("unexpected sub-triangle transaction %h", got);
        errors++;
      end else begin
        want = expected_tris.pop_front();
        check_vec("tri_p", want.p, got.p);
        check_vec("tri_q", want.q, got.q);
        check_vec("tri_r", want.r, got.r);
        if (got.last !== want.last) begin
          $error("last_triangle: expected %b actual %b", want.last, got.last); errors++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate: expected %b actual %b", want.degen, got.degen); errors++;
        end
      end
    end
    out_ch.ready <= rst_n && !(sink_stall_on && $urandom_range(99) < 16);
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input transaction; random gap beforehand, valid stays up back to back
  task automatic send_triangle(tri_in_t t);
    while (src_stall_on && $urandom_range(99) < 16) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.corner_a_x, in_ch.corner_a_y, in_ch.corner_a_z, in_ch.corner_b_x,
     in_ch.corner_b_y, in_ch.corner_b_z, in_ch.corner_c_x, in_ch.corner_c_y,
     in_ch.corner_c_z} <= t;
    do @(posedge clk); while (!in_ch.ready);
    predict_subdivision(t);
    n_in++;
  endtask

  function automatic coord_t rand_coord();
    int k;
    k = $urandom_range(99);
    if (k < 70) return coord_t'($signed($urandom_range(2*ONE)) - ONE);
    if (k < 85) return coord_t'($urandom);
    if (k < 92) return coord_t'(ONE);
    return -coord_t'(ONE);
  endfunction

  // a random direction roughly on the sphere: pick, then scale to ~unit
  function automatic vec_t rand_unit();
    vec_t v;
    real x, y, z, n;
    x = $itor($signed($urandom_range(2000)) - 1000);
    y = $itor($signed($urandom_range(2000)) - 1000);
    z = $itor($signed($urandom_range(2000)) - 1000);
    n = $sqrt(x*x + y*y + z*z);
    if (n < 1.0) begin x = 1.0; n = 1.0; end
    v.x = coord_t'($rtoi(x / n * ONE));
    v.y = coord_t'($rtoi(y / n * ONE));
    v.z = coord_t'($rtoi(z / n * ONE));
    return v;
  endfunction

  row_t table_rows[$];

  function automatic tri_in_t mk(vec_t a, vec_t b, vec_t c);
    return '{a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z};
  endfunction

  function automatic void add_row(tri_in_t t, bit has_exp, sub_tri_t e);
    row_t r;
    r.t = t;
    r.has_exp = has_exp;
    r.exp0 = e;
    table_rows.insert(table_rows.size(), r);
  endfunction

  initial begin
    tri_in_t t;
    vec_t a, b, c, px, py, pz, nx;
    sub_tri_t e;
    int k;
    px = '{16'sd16384, 0, 0}; py = '{0, 16'sd16384, 0}; pz = '{0, 0, 16'sd16384};
    nx = '{-16'sd16384, 0, 0};
    // octant face: the whole first sub-triangle, vertex and both midpoints, is typed in
    e = '{px, '{16'sd11585, 16'sd11585, 0}, '{16'sd11585, 0, 16'sd11585}, 1'b0, 1'b0};
    add_row(mk(px, py, pz), 1, e);
    // antipodal edge: zero-length midpoint, degenerate
    e = '{px, '0, '{16'sd11585, 0, 16'sd11585}, 1'b0, 1'b1};
    add_row(mk(px, nx, pz), 1, e);
    // all-zero triangle: every edge degenerate
    e = '{'0, '0, '0, 1'b0, 1'b1};
    add_row(mk('0, '0, '0), 1, e);
    // same vertex three times
    add_row(mk(py, py, py), 0, e);
    // most negative / most positive raw patterns
    add_row(mk('{-16'sd32768, -16'sd32768, -16'sd32768},
               '{16'sd32767, 16'sd32767, 16'sd32767},
               '{16'sd32767, -16'sd32768, 16'sd1}), 0, e);
    add_row(mk('{16'sd32767, 16'sd32767, 16'sd32767},
               '{16'sd32767, 16'sd32767, 16'sd32767},
               '{-16'sd32768, -16'sd32768, -16'sd32768}), 0, e);
    add_row(mk('{16'sd1, 0, 0}, '{0, 16'sd1, 0}, '{-16'sd1, 0, 0}), 0, e);
    add_row(mk(nx, '{0, -16'sd16384, 0}, '{0, 0, -16'sd16384}), 0, e);
    add_row(mk('{16'sd9459, 16'sd9459, 16'sd9459}, py,
               '{-16'sd9459, 16'sd9459, -16'sd9459}), 0, e);

    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      k = expected_tris.size();
      send_triangle(table_rows[i].t);
      if (table_rows[i].has_exp) expected_tris[k] = table_rows[i].exp0;
    end
    in_ch.valid <= 0;

    // hold off until the pipeline drains
    wait (expected_tris.size() == 0);
    @(posedge clk);

    for (int i = 0; i < 400; i++) begin
      // quiet stretch with no stalls on either side
      src_stall_on = !(i >= 150 && i < 230);
      sink_stall_on = src_stall_on;
      if ($urandom_range(99) < 80) begin
        a = rand_unit(); b = rand_unit(); c = rand_unit();
        if ($urandom_range(19) == 0) b = '{-a.x, -a.y, -a.z};
        t = mk(a, b, c);
      end else begin
        t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      end
      send_triangle(t);
    end
    in_ch.valid <= 0;

    wait (expected_tris.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d triangles in, %0d sub-triangles out, %0d degenerate inputs,",
             n_in, n_out, n_degen);
    $display("with unit-sphere, raw-pattern and antipodal cases under random stalls.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
